// File: rtl/rlkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlkd_pkg
// shared constants, types and the control program of the key decoder
// ----------------------------------------------------------------------------
package rlkd_pkg;

  localparam int GROUP_SIZE = 5;
  localparam int SAMPLE_W   = 12;
  localparam int TRIM_COUNT = GROUP_SIZE - 2;
  localparam int SUM_W      = SAMPLE_W + $clog2(GROUP_SIZE);
  localparam int CNT_W      = $clog2(GROUP_SIZE);
  localparam int DIV_CNT_W  = $clog2(SAMPLE_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int KEY_W      = 3;

  // reciprocal of the trimmed count, exact floor for any trimmed sum
  localparam int RECIP_SHIFT = SUM_W + 3;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(GROUP_SIZE - 1);
  localparam logic [RECIP_W-1:0] TRIM_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + TRIM_COUNT - 1) / TRIM_COUNT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_DIVISOR = 3'd0,
    CFG_UP_LEVEL      = 3'd1,
    CFG_DOWN_LEVEL    = 3'd2,
    CFG_RIGHT_LEVEL   = 3'd3,
    CFG_LEFT_LEVEL    = 3'd4
  } cfg_idx_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE  = 3'd0,
    KEY_UP    = 3'd1,
    KEY_DOWN  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_LEFT  = 3'd4
  } key_t;

  // program steps
  typedef enum logic [2:0] {
    STEP_COLLECT = 3'd0,
    STEP_LOAD    = 3'd1,
    STEP_DIV     = 3'd2,
    STEP_EMIT    = 3'd3,
    STEP_RETURN  = 3'd4
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NOT_LAST = 3'd2,
    C_DIV_BUSY = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  load;
    logic  div_step;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctl_word_t ucode(input step_t step);
    ctl_word_t w;
    w = '{accept: 1'b0, load: 1'b0, div_step: 1'b0,
          emit: 1'b0, cond: C_ALWAYS, target: STEP_COLLECT};
    case (step)
      STEP_COLLECT: begin
        w.accept = 1'b1;
        w.cond   = C_NOT_LAST;
        w.target = STEP_COLLECT;
      end
      STEP_LOAD: begin
        w.load = 1'b1;
        w.cond = C_NEVER;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.cond     = C_DIV_BUSY;
        w.target   = STEP_DIV;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_RETURN: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_COLLECT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_COLLECT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/resistor_ladder_key_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder_unit
// trimmed-mean filter and press latch for a resistor-ladder five-way key
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_sample: adc samples, one transfer each. samples are
//   gathered in groups of GROUP_SIZE; during gathering one sample is taken
//   per cycle.
//   out_valid/out_stall/out_key_code/out_level: one result per finished group.
//   cfg_we/cfg_index/cfg_wdata: register writes, taken at once, no read-back.
// processing
//   after the transfer of the last sample of a group the sequencer loads
//   the divider, runs the division, emits the result and returns to
//   gathering. the trimmed sum becomes the mean in one step by a reciprocal
//   multiply, then the mean is divided by scale_divisor on a shift-subtract
//   divider, one quotient bit per cycle; in_stall is high after the last
//   sample until the sequencer is back at gathering, so no sample of the
//   next group is taken before the last group is through.
// reset
//   synchronous, active low: program counter back to gathering, group empty,
//   latch armed, held key none, registers at their defaults.
// receiver stall
//   a finished result sits in the output register; the next group is
//   gathered meanwhile, and the sequencer waits at its emit step (input
//   stalled) only if the old result still has not been taken.
// ----------------------------------------------------------------------------
module resistor_ladder_key_decoder_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [rlkd_pkg::SAMPLE_W-1:0]  in_sample,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [rlkd_pkg::KEY_W-1:0]     out_key_code,
  output      logic [rlkd_pkg::SAMPLE_W-1:0]  out_level,
  input  wire logic                           cfg_we,
  input  wire logic [rlkd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlkd_pkg::SAMPLE_W-1:0]  cfg_wdata
);
  import rlkd_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0] scale_div_r;
  logic [SAMPLE_W-1:0] up_level_r;
  logic [SAMPLE_W-1:0] down_level_r;
  logic [SAMPLE_W-1:0] right_level_r;
  logic [SAMPLE_W-1:0] left_level_r;

  // sequencer
  step_t     pc_r, pc_nxt;
  ctl_word_t ctl;
  logic      jump;

  // gathering: running sum, minimum and maximum replace a sort
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;
  logic                in_fire;
  logic                last_smp;

  // trimmed mean by reciprocal multiply
  logic [SUM_W-1:0]         trim_sum;
  logic [SUM_W+RECIP_W-1:0] mean_prod;
  logic [SAMPLE_W-1:0]      mean;

  // scale divider
  logic [SAMPLE_W-1:0]  q_r;
  logic [SAMPLE_W-1:0]  rem_r;
  logic [SAMPLE_W-1:0]  d_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [SAMPLE_W:0]    trial;
  logic [SAMPLE_W:0]    diff;
  logic                 ge;
  logic [SAMPLE_W-1:0]  rem_nxt;
  logic [SAMPLE_W-1:0]  q_nxt;
  logic                 div_busy;

  // press latch and output register
  logic                armed_r, armed_nxt;
  key_t                held_key_r, held_key_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_key_code_r;
  logic [SAMPLE_W-1:0] out_level_r;
  logic [SAMPLE_W-1:0] level;
  logic                out_busy;
  logic                emit_fire;

  // ---------------------------------------------------------------------
  // control word fetch and next step
  // ---------------------------------------------------------------------
  always_comb begin
    ctl      = ucode(pc_r);
    in_fire  = in_valid && ctl.accept;
    last_smp = (cnt_r == CNT_LAST);
    out_busy = out_valid_r && out_stall;
    div_busy = (div_cnt_r != DIV_CNT_W'(1));
    case (ctl.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NOT_LAST: jump = !(in_fire && last_smp);
      C_DIV_BUSY: jump = div_busy;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
    pc_nxt = jump ? ctl.target : step_t'(pc_r + 3'd1);
  end

  assign in_stall = !ctl.accept;

  // group counter wraps after the last sample
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = last_smp ? '0 : cnt_r + CNT_W'(1);
    end
  end

  // drop the extremes, floor divide the rest by the trimmed count
  always_comb begin
    trim_sum  = sum_r - SUM_W'(min_r) - SUM_W'(max_r);
    mean_prod = {{RECIP_W{1'b0}}, trim_sum} * {{SUM_W{1'b0}}, TRIM_RECIP};
    mean      = mean_prod[RECIP_SHIFT +: SAMPLE_W];
  end

  // ---------------------------------------------------------------------
  // restoring divider, one quotient bit per step; numerator shifts out of
  // the top of q_r while quotient bits enter at the bottom
  // ---------------------------------------------------------------------
  always_comb begin
    trial   = {rem_r, q_r[SAMPLE_W-1]};
    diff    = trial - {1'b0, d_r};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    q_nxt   = {q_r[SAMPLE_W-2:0], ge};
  end

  // quotient of the scale division
  assign level = q_r;

  // ---------------------------------------------------------------------
  // press latch: first nonzero level after a release picks the key, in
  // up, down, right, left priority; a zero level re-arms
  // ---------------------------------------------------------------------
  always_comb begin
    emit_fire    = ctl.emit && !out_busy;
    armed_nxt    = armed_r;
    held_key_nxt = held_key_r;
    if (emit_fire) begin
      if (armed_r && (level != '0)) begin
        armed_nxt = 1'b0;
        if (level == up_level_r) begin
          held_key_nxt = KEY_UP;
        end else if (level == down_level_r) begin
          held_key_nxt = KEY_DOWN;
        end else if (level == right_level_r) begin
          held_key_nxt = KEY_RIGHT;
        end else if (level == left_level_r) begin
          held_key_nxt = KEY_LEFT;
        end
      end
      if (level == '0) begin
        armed_nxt    = 1'b1;
        held_key_nxt = KEY_NONE;
      end
    end
    out_valid_nxt = emit_fire || out_busy;
  end

  // ---------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= STEP_COLLECT;
      cnt_r         <= '0;
      armed_r       <= 1'b1;
      held_key_r    <= KEY_NONE;
      out_valid_r   <= 1'b0;
      scale_div_r   <= SAMPLE_W'(250);
      up_level_r    <= SAMPLE_W'(4);
      down_level_r  <= SAMPLE_W'(5);
      right_level_r <= SAMPLE_W'(8);
      left_level_r  <= SAMPLE_W'(16);
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      armed_r     <= armed_nxt;
      held_key_r  <= held_key_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE_DIVISOR: scale_div_r   <= cfg_wdata;
          CFG_UP_LEVEL:      up_level_r    <= cfg_wdata;
          CFG_DOWN_LEVEL:    down_level_r  <= cfg_wdata;
          CFG_RIGHT_LEVEL:   right_level_r <= cfg_wdata;
          CFG_LEFT_LEVEL:    left_level_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (cnt_r == '0) begin
        sum_r <= SUM_W'(in_sample);
        min_r <= in_sample;
        max_r <= in_sample;
      end else begin
        sum_r <= sum_r + SUM_W'(in_sample);
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
      end
    end
    if (ctl.load) begin
      q_r       <= mean;
      rem_r     <= '0;
      d_r       <= (scale_div_r == '0) ? SAMPLE_W'(1) : scale_div_r;
      div_cnt_r <= DIV_CNT_W'(SAMPLE_W);
    end else if (ctl.div_step) begin
      q_r       <= q_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    if (emit_fire) begin
      out_key_code_r <= held_key_nxt;
      out_level_r    <= level;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_key_code_r;
  assign out_level    = out_level_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a held key always means the latch has been disarmed
  a_held_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (held_key_r != KEY_NONE) |-> !armed_r)
    else $error("key held while latch armed");

  // divider remainder stays below the divisor throughout the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_DIV) |-> (rem_r < d_r))
    else $error("divider remainder out of range");

  // a new result only comes from the emit step
  a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == STEP_EMIT))
    else $error("result raised outside emit step");

  // running extremes stay ordered within a partial group
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (min_r <= max_r))
    else $error("group minimum above maximum");

endmodule
`default_nettype wire
